[rtl/rwa_pkg.sv]
package rwa_pkg;

    localparam int AVG_W  = 24;
    localparam int HELD_W = 9;
    localparam int SUM_W  = 32;

    localparam int DEF_MAX_WINDOW = 256;

    localparam logic [HELD_W-1:0] WLEN_RESET = HELD_W'(16);

    // saturation limits of the average, held at the width of the running sum
    localparam logic [SUM_W-1:0] AVG_POS_LIM = SUM_W'(2 ** (AVG_W - 1) - 1);
    localparam logic [SUM_W-1:0] AVG_NEG_LIM = SUM_W'(2 ** (AVG_W - 1));

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [AVG_W-1:0]  sample;
    } rwa_in_t;

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [HELD_W-1:0] samples_held;
        logic              window_full;
    } rwa_out_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [HELD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [AVG_W-1:0]  quotient;
    } div_rsp_t;

endpackage

[rtl/rwa_ram.sv]
module rwa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rwa_divider.sv]
module rwa_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rwa_pkg::div_req_t req,
    output rwa_pkg::div_rsp_t rsp
);

    localparam int SUM_W  = rwa_pkg::SUM_W;
    localparam int HELD_W = rwa_pkg::HELD_W;
    localparam int AVG_W  = rwa_pkg::AVG_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HELD_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [HELD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [AVG_W-1:0]  result_reg, result_next;

    logic [HELD_W:0]   shifted;
    logic [HELD_W+1:0] diff;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            neg_next  = req.dividend[SUM_W-1];
            quo_next  = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (!diff[HELD_W+1])
            begin
                rem_next = diff[HELD_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[HELD_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        else if (busy_reg)
        begin
            // restore the sign and clamp to the output range
            busy_next = 1'b0;
            done_next = 1'b1;
            if (neg_reg)
            begin
                if (quo_reg > rwa_pkg::AVG_NEG_LIM)
                begin
                    result_next = rwa_pkg::AVG_NEG_LIM[AVG_W-1:0];
                end
                else
                begin
                    result_next = ~quo_reg[AVG_W-1:0] + AVG_W'(1);
                end
            end
            else if (quo_reg > rwa_pkg::AVG_POS_LIM)
            begin
                result_next = rwa_pkg::AVG_POS_LIM[AVG_W-1:0];
            end
            else
            begin
                result_next = quo_reg[AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

endmodule

[rtl/running_window_average_core.sv]
// Moving average over the last window_length samples, held in a ring store.
// A sample transaction steps through SUB, ADD, START, WAIT and DONE; WAIT
// covers the 32 steps of the one-bit-a-cycle divider. A clear goes straight
// to DONE. DONE holds the result until the output register is free, and no
// new transaction is accepted until the block is back in idle.
// Reset: pointer, fill count and sum to zero, window length to 16; store kept.
module running_window_average_core #(
    parameter int MAX_WINDOW = rwa_pkg::DEF_MAX_WINDOW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  rwa_pkg::rwa_in_t           sample_item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output rwa_pkg::rwa_out_t          result_item,
    input  logic                       wlen_valid,
    output logic                       wlen_ready,
    input  logic [rwa_pkg::HELD_W-1:0] wlen_data
);

    localparam int AVG_W  = rwa_pkg::AVG_W;
    localparam int HELD_W = rwa_pkg::HELD_W;
    localparam int SUM_W  = rwa_pkg::SUM_W;
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // wide enough to compare pointer, length and MAX_WINDOW without wrapping
    localparam int CMP_W  = ((ADDR_W > HELD_W) ? ADDR_W : HELD_W) + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUB   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [HELD_W-1:0] wlen_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [HELD_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AVG_W-1:0]  smp_reg, smp_next;
    rwa_pkg::rwa_out_t res_reg, res_next;
    logic              result_valid_reg, result_valid_next;
    rwa_pkg::rwa_out_t result_item_reg, result_item_next;

    logic [HELD_W-1:0] len_eff;
    logic [ADDR_W-1:0] ptr_adj;
    logic [ADDR_W-1:0] ptr_wrap;
    logic [SUM_W-1:0]  smp_ext;
    logic              accept;
    logic              out_free;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [AVG_W-1:0]  ram_rd_data;

    rwa_pkg::div_req_t div_req;
    rwa_pkg::div_rsp_t div_rsp;

    // ------------------------------------------------------------------
    // Window length register; to be written by the user only while the filter is idle, not enforced by the block.
    // ------------------------------------------------------------------
    assign wlen_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= rwa_pkg::WLEN_RESET;
        end
        else if (wlen_valid && wlen_ready)
        begin
            wlen_reg <= wlen_data;
        end
    end

    // Effective length: zero acts as one, anything past the store depth is
    // clamped to the depth.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = HELD_W'(1);
        end
        else if (CMP_W'(wlen_reg) > CMP_W'(MAX_WINDOW))
        begin
            len_eff = HELD_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = wlen_reg;
        end
    end

    // Restart the pointer if a shorter window left it outside the ring.
    assign ptr_adj  = (CMP_W'(ptr_reg) >= CMP_W'(len_eff)) ? '0 : ptr_reg;
    assign ptr_wrap = ((CMP_W'(ptr_reg) + CMP_W'(1)) == CMP_W'(len_eff)) ?
                      '0 : (ptr_reg + ADDR_W'(1));

    assign smp_ext  = {{(SUM_W - AVG_W){smp_reg[AVG_W-1]}}, smp_reg};

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    // the output register may take a new result when empty or being drained
    assign out_free     = !result_valid_reg || !result_stall;

    // ------------------------------------------------------------------
    // Ring store: read the slot to be overwritten at acceptance, write the
    // new sample in the S_ADD state, which follows S_SUB.
    // ------------------------------------------------------------------
    assign ram_rd_en = accept && (sample_item.op == rwa_pkg::OP_SAMPLE);
    assign ram_wr_en = (state_reg == S_ADD);

    rwa_ram #(
        .WIDTH (AVG_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (smp_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_adj),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Divider: running sum over fill count, saturated to 24 bits.
    // ------------------------------------------------------------------
    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = fill_reg;

    rwa_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        smp_next          = smp_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg;
        result_item_next  = result_item_reg;

        // drop the result once the far side has taken it
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample_item.op == rwa_pkg::OP_CLEAR)
                    begin
                        ptr_next   = '0;
                        fill_next  = '0;
                        sum_next   = '0;
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_adj;
                        smp_next   = sample_item.sample;
                        state_next = S_SUB;
                    end
                end
            end
            S_SUB:
            begin
                // grow the window, or retire the oldest sample once it is full
                if (fill_reg < len_eff)
                begin
                    fill_next = fill_reg + HELD_W'(1);
                end
                else
                begin
                    sum_next = sum_reg - {{(SUM_W - AVG_W){ram_rd_data[AVG_W-1]}},
                                          ram_rd_data};
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next   = sum_reg + smp_ext;
                ptr_next   = ptr_wrap;
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next.average      = div_rsp.quotient;
                    res_next.samples_held = fill_reg;
                    res_next.window_full  = (fill_reg >= len_eff);
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    result_item_next  = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ptr_reg          <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg         <= smp_next;
        res_reg         <= res_next;
        result_item_reg <= result_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample_item.op == rwa_pkg::OP_CLEAR)) |=>
            ((fill_reg == '0) && (sum_reg == '0) && (state_reg == S_DONE)))
        else $error("clear transaction did not empty the filter");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised without a finished transaction");

    a_full_needs_samples: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_item_reg.window_full &&
                               (result_item_reg.samples_held == '0)))
        else $error("full window reported with no samples held");

endmodule

[tb/sv/rwa_result_checker.sv]
`timescale 1ns / 100ps

module rwa_result_checker #(
    parameter int MAX_WINDOW = rwa_pkg::DEF_MAX_WINDOW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    input  logic                       sample_stall,
    input  rwa_pkg::rwa_in_t           sample_item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  rwa_pkg::rwa_out_t          result_item,
    input  logic                       wlen_valid,
    input  logic                       wlen_ready,
    input  logic [rwa_pkg::HELD_W-1:0] wlen_data,
    output int                         errors,
    output int                         pending
);

    localparam int SAT_HIGH = 2 ** (rwa_pkg::AVG_W - 1) - 1;
    localparam int SAT_LOW  = -(2 ** (rwa_pkg::AVG_W - 1));

    // shadow copy of the filter
    logic [rwa_pkg::SUM_W-1:0]  ring [MAX_WINDOW];
    logic [rwa_pkg::SUM_W-1:0]  run_sum;
    logic [rwa_pkg::HELD_W-1:0] wlen_reg;
    int                         wr_ptr;
    int                         held;

    rwa_pkg::rwa_out_t expected_averages [$];
    rwa_pkg::rwa_out_t want;
    int                result_no;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, result_no, what, got, exp_val);
        errors++;
    endtask

    function automatic rwa_pkg::rwa_out_t predict_average(input rwa_pkg::rwa_in_t item);
        rwa_pkg::rwa_out_t         r;
        int                        eff;
        logic [rwa_pkg::SUM_W-1:0] ext;
        longint                    quot;
        eff = int'(wlen_reg);
        if (eff < 1)
            eff = 1;
        if (eff > MAX_WINDOW)
            eff = MAX_WINDOW;
        r = '0;
        if (item.op == rwa_pkg::OP_CLEAR)
        begin
            wr_ptr  = 0;
            held    = 0;
            run_sum = '0;
            return r;
        end
        // restart the pointer if the window shrank beneath it
        if (wr_ptr >= eff)
            wr_ptr = 0;
        if (held < eff)
            held++;
        else
            run_sum = run_sum - ring[wr_ptr];
        ext = {{(rwa_pkg::SUM_W - rwa_pkg::AVG_W){item.sample[rwa_pkg::AVG_W-1]}},
               item.sample};
        ring[wr_ptr] = ext;
        run_sum      = run_sum + ext;
        wr_ptr       = (wr_ptr + 1) % eff;
        quot = longint'($signed(run_sum)) / longint'(held);
        if (quot > SAT_HIGH)
            quot = SAT_HIGH;
        if (quot < SAT_LOW)
            quot = SAT_LOW;
        r.average      = quot[rwa_pkg::AVG_W-1:0];
        r.samples_held = held[rwa_pkg::HELD_W-1:0];
        r.window_full  = (held >= eff);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr    = 0;
            held      = 0;
            run_sum   = '0;
            wlen_reg  = rwa_pkg::WLEN_RESET;
            result_no = 0;
            errors    = 0;
            pending   = 0;
            expected_averages.delete();
        end
        else
        begin
            // compare before taking new input: no result can belong to an
            // input accepted on the same edge
            if (result_valid && !result_stall)
            begin
                if (expected_averages.size() == 0)
                    report_mismatch("unexpected result, average",
                                    int'($signed(result_item.average)), 0);
                else
                begin
                    want = expected_averages.pop_front();
                    if (result_item.average !== want.average)
                        report_mismatch("average", int'($signed(result_item.average)),
                                        int'($signed(want.average)));
                    if (result_item.samples_held !== want.samples_held)
                        report_mismatch("samples_held", int'(result_item.samples_held),
                                        int'(want.samples_held));
                    if (result_item.window_full !== want.window_full)
                        report_mismatch("window_full", int'(result_item.window_full),
                                        int'(want.window_full));
                end
                result_no++;
            end
            if (wlen_valid && wlen_ready)
                wlen_reg = wlen_data;
            if (sample_valid && !sample_stall)
                expected_averages.push_back(predict_average(sample_item));
            pending = expected_averages.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int AW = rwa_pkg::AVG_W;
    localparam int HW = rwa_pkg::HELD_W;

    // extremes of the signed sample range
    localparam logic [AW-1:0] SAMPLE_MAX = {1'b0, {(AW - 1){1'b1}}};
    localparam logic [AW-1:0] SAMPLE_MIN = {1'b1, {(AW - 1){1'b0}}};

    localparam int FULL_WINDOW     = rwa_pkg::DEF_MAX_WINDOW;
    localparam int RANDOM_ITEMS    = 200;
    localparam int HOLD_OFF_CYCLES = 600;
    // a clear answers sooner than a sample, which waits on the divider
    localparam int DRAIN_CYCLES    = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    rwa_pkg::rwa_in_t     sample_item;
    logic                 result_valid;
    logic                 result_stall;
    rwa_pkg::rwa_out_t    result_item;
    logic                 wlen_valid;
    logic                 wlen_ready;
    logic [HW-1:0]        wlen_data;

    int errors;
    int pending;
    int items_sent;
    int burst_left;
    bit hold_off_req;

    running_window_average_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .wlen_valid   (wlen_valid),
        .wlen_ready   (wlen_ready),
        .wlen_data    (wlen_data)
    );

    // Watch all three channels, predict and compare; the top only drives.
    rwa_result_checker avg_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .wlen_valid   (wlen_valid),
        .wlen_ready   (wlen_ready),
        .wlen_data    (wlen_data),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one transaction and hold it until accepted. Keep valid high
    // while a burst lasts; at the end of a burst drop valid for a random
    // gap and draw the next burst length. Now and then a long burst gives
    // a stretch with no idling on the input side.
    task automatic offer_item(input rwa_pkg::rwa_in_t item);
        sample_item  <= item;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(20, 80);
            else
                burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic send_sample(input logic [AW-1:0] value);
        offer_item('{op: rwa_pkg::OP_SAMPLE, sample: value});
    endtask

    // the sample field of a clear carries junk on purpose
    task automatic send_clear();
        offer_item('{op: rwa_pkg::OP_CLEAR, sample: AW'($urandom)});
    endtask

    // Drop valid and wait until every outstanding transaction has produced
    // its result, then let the block go quiet before returning.
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the window length register; only ever done with the block idle.
    task automatic write_window(input logic [HW-1:0] len);
        settle();
        wlen_data  <= len;
        wlen_valid <= 1'b1;
        do
            @(posedge clk);
        while (!wlen_ready);
        wlen_valid <= 1'b0;
    endtask

    function automatic logic [AW-1:0] random_sample();
        int v;
        v = $urandom_range(0, 200);
        v = v - 100;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return v[AW-1:0];
            default: return AW'($urandom);
        endcase
    endfunction

    // Receiver: pick a stall mode for a random span, cycle through modes.
    // Once asked, hold off completely for a long stretch so that the block
    // fills and has to stall its input.
    initial
    begin
        int mode;
        int span;
        int tick;
        int period;
        result_stall <= 1'b0;
        tick = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(50, 300);
            period = $urandom_range(2, 9);
            while (span > 0)
            begin
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    result_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 9) < 3);
                    2:       result_stall <= ($urandom_range(0, 9) < 8);
                    default: result_stall <= ((tick % period) < (period / 2));
                endcase
                @(posedge clk);
                tick++;
                span--;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int               start;
        int               n;
        logic [HW-1:0]    len;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_item  <= '0;
        wlen_valid   <= 1'b0;
        wlen_data    <= '0;
        items_sent   = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Run a few samples on the reset window length first; fewer than 16
        // so no unwritten store entry is ever subtracted from the sum.
        send_sample(AW'(100));
        send_sample(AW'(-7));
        send_sample(SAMPLE_MAX);

        // Fill every store entry with the most negative value. From here on
        // the store holds no unwritten entry, so window changes without a
        // clear are safe in any order.
        write_window(HW'(FULL_WINDOW));
        send_clear();
        repeat (FULL_WINDOW) send_sample(SAMPLE_MIN);

        // Truncation toward zero on a two-sample window.
        write_window(HW'(2));
        send_clear();
        send_sample(AW'(-3));
        send_sample(AW'(0));
        send_sample(AW'(1));
        send_sample(AW'(-1));

        // Grow the window without a clear: fill count kept, averages drift.
        write_window(HW'(5));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(AW'(-1));

        // Shrink it without a clear so the pointer lands beyond the window.
        write_window(HW'(3));
        send_sample(AW'(1));
        send_sample(AW'(0));

        // Zero acts as a one-sample window.
        write_window(HW'(0));
        send_sample(SAMPLE_MIN);
        send_sample(AW'(7));

        // All ones and just above the maximum both act as the full window.
        write_window('1);
        send_clear();
        send_sample(AW'(123));
        send_sample(AW'(-123));
        write_window(HW'(FULL_WINDOW + 1));
        send_sample(SAMPLE_MAX);

        // Clear with every sample bit set, then a sample into the empty filter.
        offer_item('{op: rwa_pkg::OP_CLEAR, sample: '1});
        send_sample(AW'(0));

        // Random phases: a window setting, usually a clear, then a run of
        // items. Ask the receiver for its long hold-off as this part starts.
        hold_off_req = 1'b1;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = HW'($urandom_range(FULL_WINDOW + 1, (1 << HW) - 1));
                2:       len = HW'(FULL_WINDOW);
                3:       len = HW'(1);
                default: len = HW'($urandom_range(2, 40));
            endcase
            write_window(len);
            if ($urandom_range(0, 3) != 0)
                send_clear();
            n = $urandom_range(5, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 14) == 0)
                    send_clear();
                else
                    send_sample(random_sample());
            end
        end

        // Drain, then give the block time to show any stray result.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Safety net: the slowest correct run is well under a fifth of this.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[running_window_average_core.f]
rtl/rwa_pkg.sv
rtl/rwa_ram.sv
rtl/rwa_divider.sv
rtl/running_window_average_core.sv
tb/sv/rwa_result_checker.sv
tb/sv/tb_top.sv
